// File: rtl/core/dss_pkg.sv
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types and constants for the delimiter string splitter: item and
// result layouts, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package dss_pkg;

	// window depth, also the longest delimiter supported
	localparam int MAX_DELIM_BYTES = 8;

	// configuration register indexes
	localparam logic [1:0] CFG_DELIM_BYTES  = 2'd0;
	localparam logic [1:0] CFG_DELIM_LENGTH = 2'd1;
	localparam logic [1:0] CFG_SPLIT_LIMIT  = 2'd2;

	// configuration reset values
	localparam logic [63:0] RST_DELIM_BYTES  = 64'd44;
	localparam logic [3:0]  RST_DELIM_LENGTH = 4'd1;
	localparam logic [30:0] RST_SPLIT_LIMIT  = 31'h7fff_ffff;

	// one input item
	typedef struct packed {
		logic [7:0] in_byte;
		logic       has_byte;
		logic       is_last;
	} item_t;

	// one result item
	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       piece_end;
		logic       string_end;
		logic       bad_delimiter;
	} result_t;

	// configuration register set
	typedef struct packed {
		logic [63:0] delimiter_bytes;
		logic [3:0]  delimiter_length;
		logic [30:0] split_limit;
	} cfg_t;

endpackage

// File: rtl/core/dss_in_stage.sv
// ----------------------------------------------------------------------------
// dss_in_stage
// Input register: holds one item until the engine has finished with it.
// ----------------------------------------------------------------------------
module dss_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  dss_pkg::item_t  in_item,
	output logic            item_valid,
	output dss_pkg::item_t  item,
	input  logic            take
);

	logic           valid_q;
	dss_pkg::item_t item_q;

	// free, or being emptied this cycle
	assign in_ready   = !valid_q || take;
	assign item_valid = valid_q;
	assign item       = item_q;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= in_item;
		end
	end

endmodule

// File: rtl/core/dss_engine.sv
// ----------------------------------------------------------------------------
// dss_engine
// Splitting state (window, count, splits left, string start flag) and the
// per-cycle step, held while the output is full; at most one result per step.
// ----------------------------------------------------------------------------
module dss_engine #(
	parameter int MAX_DELIM_BYTES = dss_pkg::MAX_DELIM_BYTES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dss_pkg::cfg_t     cfg,
	input  logic              item_valid,
	input  dss_pkg::item_t    item,
	output logic              take,
	input  logic              out_free,
	output logic              res_valid,
	output dss_pkg::result_t  res
);

	localparam int CW = $clog2(MAX_DELIM_BYTES + 1);

	logic [7:0]    win_q [MAX_DELIM_BYTES];
	logic [7:0]    win_n [MAX_DELIM_BYTES];
	logic [CW-1:0] cnt_q, cnt_n, cnt_e;
	logic [30:0]   spl_q, spl_n, spl_e, spl_init;
	logic          fresh_q, fresh_n;
	logic          tail_q, tail_n;
	logic [CW-1:0] d;
	logic          active, fire, done, res_v, go_tail, matched;
	dss_pkg::result_t res_c;

	// effective delimiter length, clamped to the window depth
	always_comb begin
		if (cfg.delimiter_length > 4'(MAX_DELIM_BYTES)) begin
			d = CW'(MAX_DELIM_BYTES);
		end else begin
			d = CW'(cfg.delimiter_length);
		end
	end

	// state as seen by this step, with string start applied
	assign spl_init = (cfg.split_limit <= 31'd1) ? 31'd0 : cfg.split_limit - 31'd1;
	assign spl_e    = fresh_q ? spl_init : spl_q;
	assign cnt_e    = fresh_q ? '0 : cnt_q;

	assign active = item_valid && (item.has_byte || item.is_last);
	assign fire   = active && out_free;

	// one step of the item
	always_comb begin
		win_n   = win_q;
		cnt_n   = cnt_e;
		spl_n   = spl_e;
		tail_n  = tail_q;
		res_c   = '0;
		res_v   = 1'b0;
		done    = 1'b0;
		matched = 1'b1;
		go_tail = tail_q || !item.has_byte;
		if (d == '0) begin
			// bad delimiter: bytes dropped, one error mark at string end
			done = 1'b1;
			if (item.is_last) begin
				res_v               = 1'b1;
				res_c.string_end    = 1'b1;
				res_c.bad_delimiter = 1'b1;
				cnt_n               = '0;
			end
		end else begin
			// byte phase
			if (!go_tail) begin
				if (spl_n != '0) begin
					if (cnt_n >= d) begin
						// window too full after a length change
						res_v            = 1'b1;
						res_c.out_byte   = win_n[0];
						res_c.byte_valid = 1'b1;
						for (int i = 0; i < MAX_DELIM_BYTES - 1; i++) begin
							win_n[i] = win_n[i+1];
						end
						cnt_n = cnt_n - CW'(1);
					end else begin
						for (int i = 0; i < MAX_DELIM_BYTES; i++) begin
							if (CW'(i) == cnt_n) begin
								win_n[i] = item.in_byte;
							end
						end
						cnt_n   = cnt_n + CW'(1);
						go_tail = 1'b1;
						if (cnt_n == d) begin
							for (int j = 0; j < MAX_DELIM_BYTES; j++) begin
								if (CW'(j) < d &&
								    win_n[j] != cfg.delimiter_bytes[8*j +: 8]) begin
									matched = 1'b0;
								end
							end
							res_v = 1'b1;
							if (matched) begin
								res_c.piece_end = 1'b1;
								cnt_n           = '0;
								spl_n           = spl_n - 31'd1;
							end else begin
								res_c.out_byte   = win_n[0];
								res_c.byte_valid = 1'b1;
								for (int i = 0; i < MAX_DELIM_BYTES - 1; i++) begin
									win_n[i] = win_n[i+1];
								end
								cnt_n = cnt_n - CW'(1);
							end
						end
					end
				end else begin
					// no splits left: drain, then pass the byte through
					if (cnt_n != '0) begin
						res_v            = 1'b1;
						res_c.out_byte   = win_n[0];
						res_c.byte_valid = 1'b1;
						for (int i = 0; i < MAX_DELIM_BYTES - 1; i++) begin
							win_n[i] = win_n[i+1];
						end
						cnt_n = cnt_n - CW'(1);
					end else begin
						win_n[0] = item.in_byte;
						cnt_n    = CW'(1);
						go_tail  = 1'b1;
					end
				end
			end
			// tail phase: string end flush or pass-through drain
			if (go_tail) begin
				if (res_v) begin
					if (item.is_last || (spl_n == '0 && cnt_n != '0)) begin
						tail_n = 1'b1;
					end else begin
						done = 1'b1;
					end
				end else if (item.is_last) begin
					res_v = 1'b1;
					if (cnt_n == '0) begin
						res_c.piece_end  = 1'b1;
						res_c.string_end = 1'b1;
						done             = 1'b1;
					end else begin
						res_c.out_byte   = win_n[0];
						res_c.byte_valid = 1'b1;
						res_c.piece_end  = (cnt_n == CW'(1));
						res_c.string_end = (cnt_n == CW'(1));
						done             = (cnt_n == CW'(1));
						for (int i = 0; i < MAX_DELIM_BYTES - 1; i++) begin
							win_n[i] = win_n[i+1];
						end
						cnt_n  = cnt_n - CW'(1);
						tail_n = 1'b1;
					end
				end else if (spl_n == '0 && cnt_n != '0) begin
					res_v            = 1'b1;
					res_c.out_byte   = win_n[0];
					res_c.byte_valid = 1'b1;
					done             = (cnt_n == CW'(1));
					for (int i = 0; i < MAX_DELIM_BYTES - 1; i++) begin
						win_n[i] = win_n[i+1];
					end
					cnt_n  = cnt_n - CW'(1);
					tail_n = 1'b1;
				end else begin
					done = 1'b1;
				end
			end
		end
		if (done) begin
			tail_n = 1'b0;
		end
		fresh_n = done && item.is_last;
	end

	assign take      = item_valid && (!active || (out_free && done));
	assign res_valid = fire && res_v;
	assign res       = res_c;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			spl_q   <= '0;
			fresh_q <= 1'b1;
			tail_q  <= 1'b0;
		end else if (fire) begin
			cnt_q   <= cnt_n;
			spl_q   <= spl_n;
			fresh_q <= fresh_n;
			tail_q  <= tail_n;
		end
	end

	// window bytes, read only below the count
	always_ff @(posedge clk) begin
		if (fire) begin
			win_q <= win_n;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_DELIM_BYTES))
		else $error("window count above depth");

	a_tail_mid_string: assert property (@(posedge clk) disable iff (!arst_n)
		tail_q |-> !fresh_q)
		else $error("flush phase pending at string start");

	a_res_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> out_free && (res.byte_valid || res.out_byte == 8'd0))
		else $error("result produced without room or with stray byte");

endmodule

// File: rtl/core/dss_out_stage.sv
// ----------------------------------------------------------------------------
// dss_out_stage
// Output register: holds one result item while the consumer stalls.
// ----------------------------------------------------------------------------
module dss_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  dss_pkg::result_t  res,
	output logic              out_free,
	output logic              out_valid,
	input  logic              out_ready,
	output dss_pkg::result_t  out_item
);

	logic             valid_q;
	dss_pkg::result_t data_q;

	// empty, or being drained this cycle
	assign out_free  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_item  = data_q;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= load;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res;
		end
	end

endmodule

// File: rtl/core/delimiter_string_splitter.sv
// ----------------------------------------------------------------------------
// delimiter_string_splitter
// Splits a byte string at leftmost non-overlapping delimiters, up to a limit.
// ----------------------------------------------------------------------------
// An ordinary byte item gives at most one result item and is taken from the
// input register as that result is loaded, so a steady stream runs at one
// item per cycle while the output register is free. The item that ends a
// string stays in the input register while the pending window (up to
// MAX_DELIM_BYTES bytes) is flushed one byte per cycle through the single
// output register, as long as that register is free. After the delimiter
// length is shortened mid-string, the next byte first releases each surplus
// window byte as a result item of its own. Input and output each have one
// register stage; results are formed combinationally between the two.
// ----------------------------------------------------------------------------
module delimiter_string_splitter #(
	parameter int MAX_DELIM_BYTES = dss_pkg::MAX_DELIM_BYTES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [63:0]       cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  dss_pkg::item_t    in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output dss_pkg::result_t  out_item
);

	dss_pkg::cfg_t    cfg_q;
	dss_pkg::item_t   item;
	dss_pkg::result_t res;
	logic             item_valid, take, out_free, res_valid;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delimiter_bytes  <= dss_pkg::RST_DELIM_BYTES;
			cfg_q.delimiter_length <= dss_pkg::RST_DELIM_LENGTH;
			cfg_q.split_limit      <= dss_pkg::RST_SPLIT_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dss_pkg::CFG_DELIM_BYTES:  cfg_q.delimiter_bytes  <= cfg_data;
				dss_pkg::CFG_DELIM_LENGTH: cfg_q.delimiter_length <= cfg_data[3:0];
				dss_pkg::CFG_SPLIT_LIMIT:  cfg_q.split_limit      <= cfg_data[30:0];
				default: begin
				end
			endcase
		end
	end

	// input register
	dss_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.item_valid (item_valid),
		.item       (item),
		.take       (take)
	);

	// splitting step
	dss_engine #(
		.MAX_DELIM_BYTES (MAX_DELIM_BYTES)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item       (item),
		.take       (take),
		.out_free   (out_free),
		.res_valid  (res_valid),
		.res        (res)
	);

	// result register
	dss_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_valid),
		.res       (res),
		.out_free  (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

// File: bench/delimiter_string_splitter_tb.sv
// ----------------------------------------------------------------------------
// delimiter_string_splitter_tb
// Self-checking bench for the delimiter string splitter. Byte items go in
// through the valid/ready input, and a behavioral model of the splitter
// predicts the piece bytes and end marks that each accepted item causes.
// Result items are compared field by field in arrival order. Directed tests
// cover the corner cases. Random phases change the configuration and send
// strings built from delimiter copies and noise, with idle gaps on both sides.
// ----------------------------------------------------------------------------
module delimiter_string_splitter_tb;

	// write to this index must be ignored
	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 100;
	localparam int SETTLE_CYCLES = 3 * dss_pkg::MAX_DELIM_BYTES;
	localparam int STALL_LIMIT = 3000;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [1:0]       cfg_index;
	logic [63:0]      cfg_data;
	logic             in_valid;
	logic             in_ready;
	dss_pkg::item_t   in_item;
	logic             out_valid;
	logic             out_ready;
	dss_pkg::result_t out_item;

	// splitter model state and configuration mirror
	logic [63:0] cfg_delim_bytes = dss_pkg::RST_DELIM_BYTES;
	logic [3:0]  cfg_delim_len = dss_pkg::RST_DELIM_LENGTH;
	logic [30:0] cfg_limit = dss_pkg::RST_SPLIT_LIMIT;
	logic [7:0]  win_bytes [dss_pkg::MAX_DELIM_BYTES] = '{default: 8'h00};
	int unsigned win_count = 0;
	logic [30:0] splits_left = '0;
	bit          string_fresh = 1'b1;

	// piece bytes and end marks still to come out of the block
	dss_pkg::result_t piece_stream [$];
	dss_pkg::result_t want_item;

	int          fail_count = 0;
	int          stalled = 0;
	bit          tx_gaps_on = 1'b1;
	bit          rx_gaps_on = 1'b1;
	int          rx_hold_req = 0;
	int          rx_stall = 0;

	delimiter_string_splitter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// splitter model
	// ------------------------------------------------------------------------

	function automatic void push_piece(logic [7:0] b, bit valid, bit pe, bit se, bit bad);
		dss_pkg::result_t r;
		r.out_byte = valid ? b : 8'h00;
		r.byte_valid = valid;
		r.piece_end = pe;
		r.string_end = se;
		r.bad_delimiter = bad;
		piece_stream = {piece_stream, r};
	endfunction

	// oldest window byte leaves as a piece byte
	function automatic void release_oldest();
		int unsigned i;
		if (win_count == 0)
			return;
		push_piece(win_bytes[0], 1'b1, 1'b0, 1'b0, 1'b0);
		for (i = 1; i < win_count; i++)
			win_bytes[i - 1] = win_bytes[i];
		win_count--;
	endfunction

	function automatic void take_byte(logic [7:0] b);
		if (win_count >= dss_pkg::MAX_DELIM_BYTES)
			release_oldest();
		win_bytes[win_count % dss_pkg::MAX_DELIM_BYTES] = b;
		win_count++;
	endfunction

	function automatic bit window_is_delim(int unsigned d);
		int unsigned j;
		for (j = 0; j < d; j++)
			if (win_bytes[j] != cfg_delim_bytes[8 * j +: 8])
				return 1'b0;
		return 1'b1;
	endfunction

	// work out the results of one accepted item
	function automatic void split_item(dss_pkg::item_t it);
		int unsigned d;
		int unsigned i;
		bit fin;
		if (!it.has_byte && !it.is_last)
			return;
		// first item of a string
		if (string_fresh) begin
			splits_left = (cfg_limit <= 1) ? '0 : cfg_limit - 31'd1;
			win_count = 0;
			string_fresh = 1'b0;
		end
		d = (cfg_delim_len > dss_pkg::MAX_DELIM_BYTES) ?
			dss_pkg::MAX_DELIM_BYTES : cfg_delim_len;
		// zero length: drop bytes, flag at string end
		if (d == 0) begin
			if (it.is_last) begin
				push_piece(8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
				win_count = 0;
				string_fresh = 1'b1;
			end
			return;
		end
		if (it.has_byte) begin
			if (splits_left != 0) begin
				while (win_count >= d)
					release_oldest();
				take_byte(it.in_byte);
				if (win_count == d) begin
					if (window_is_delim(d)) begin
						push_piece(8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
						win_count = 0;
						splits_left--;
					end else begin
						release_oldest();
					end
				end
			end else begin
				while (win_count > 0)
					release_oldest();
				take_byte(it.in_byte);
			end
		end
		// string end flushes the window into the final piece
		if (it.is_last) begin
			if (win_count == 0) begin
				push_piece(8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
			end else begin
				for (i = 0; i < win_count; i++) begin
					fin = (i + 1 == win_count);
					push_piece(win_bytes[i], 1'b1, fin, fin, 1'b0);
				end
			end
			win_count = 0;
			string_fresh = 1'b1;
		end else if (splits_left == 0) begin
			while (win_count > 0)
				release_oldest();
		end
	endfunction

	// ------------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------------

	// gap length: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return 0;
		else if (r < 93)
			return $urandom_range(1, 3);
		else if (r < 99)
			return $urandom_range(4, 12);
		else
			return $urandom_range(25, 70);
	endfunction

	// one item through the input handshake, then into the model
	task automatic send_item(logic [7:0] b, bit has, bit last);
		dss_pkg::item_t it;
		int gap;
		it.in_byte = b;
		it.has_byte = has;
		it.is_last = last;
		@(negedge clk);
		gap = tx_gaps_on ? pick_gap() : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do
			@(posedge clk);
		while (!in_ready);
		split_item(it);
	endtask

	task automatic send_text(string s, bit close);
		int i;
		for (i = 0; i < s.len(); i++)
			send_item(s[i], 1'b1, close && (i + 1 == s.len()));
	endtask

	// stop sending, wait for every result, then let the block settle
	task automatic wait_block_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (piece_stream.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(logic [1:0] idx, logic [63:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			dss_pkg::CFG_DELIM_BYTES: cfg_delim_bytes = value;
			dss_pkg::CFG_DELIM_LENGTH: cfg_delim_len = value[3:0];
			dss_pkg::CFG_SPLIT_LIMIT: cfg_limit = value[30:0];
			default: ;
		endcase
	endtask

	// delimiter text packed first byte lowest
	function automatic logic [63:0] text_to_delim(string s);
		logic [63:0] v;
		int i;
		v = '0;
		for (i = 0; i < s.len() && i < 8; i++)
			v[8 * i +: 8] = s[i];
		return v;
	endfunction

	function automatic logic [7:0] alphabet_byte();
		case ($urandom_range(0, 3))
			0: return 8'h2c;
			1: return 8'h61;
			2: return 8'h00;
			default: return 8'hff;
		endcase
	endfunction

	// string content biased toward delimiter bytes
	function automatic logic [7:0] pick_symbol();
		int r;
		int k;
		r = $urandom_range(0, 9);
		k = $urandom_range(0, 7);
		if (r < 5)
			return cfg_delim_bytes[8 * k +: 8];
		else if (r < 9)
			return alphabet_byte();
		else
			return 8'($urandom_range(0, 255));
	endfunction

	// receiver: random stalls plus requested long hold-offs
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_req != 0) begin
				rx_stall = rx_hold_req;
				rx_hold_req = 0;
			end
			if (rx_stall != 0) begin
				out_ready <= 1'b0;
				rx_stall--;
			end else begin
				out_ready <= 1'b1;
				if (rx_gaps_on)
					rx_stall = pick_gap();
			end
		end
	end

	// ------------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------------

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			fail_count++;
		end
	endfunction

	// each result item against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (piece_stream.size() == 0) begin
				$display("%0t: result item with nothing expected, actual %h", $time, out_item);
				fail_count++;
			end else begin
				want_item = piece_stream.pop_front();
				check_field("out_byte", want_item.out_byte, out_item.out_byte);
				check_field("byte_valid", 8'(want_item.byte_valid),
					8'(out_item.byte_valid));
				check_field("piece_end", 8'(want_item.piece_end),
					8'(out_item.piece_end));
				check_field("string_end", 8'(want_item.string_end),
					8'(out_item.string_end));
				check_field("bad_delimiter", 8'(want_item.bad_delimiter),
					8'(out_item.bad_delimiter));
			end
		end
	end

	// watchdog on cycles with no item moving
	initial begin
		while (stalled < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stalled = 0;
			else
				stalled++;
		end
		$display("delimiter_string_splitter_tb failed");
		$finish;
	end

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// single comma delimiter from reset: empty strings and empty pieces
	task automatic test_basic_split();
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'h5a, 1'b0, 1'b0);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'h2c, 1'b1, 1'b0);
		send_item(8'h2c, 1'b1, 1'b0);
		send_item(8'hff, 1'b1, 1'b1);
		// string ending on the delimiter
		send_text("x,", 1'b1);
		// string closed by an item with no byte
		send_item(8'h79, 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
	endtask

	// multi-byte delimiter, partial match at string end, oversized length
	task automatic test_long_delimiter();
		int k;
		wait_block_idle();
		cfg_write(dss_pkg::CFG_DELIM_BYTES, text_to_delim("abc"));
		cfg_write(dss_pkg::CFG_DELIM_LENGTH, 64'd3);
		send_text("xabcab", 1'b1);
		wait_block_idle();
		cfg_write(dss_pkg::CFG_DELIM_BYTES, '1);
		cfg_write(dss_pkg::CFG_DELIM_LENGTH, 64'd15);
		for (k = 0; k < 8; k++)
			send_item(8'hff, 1'b1, 1'b0);
		send_item(8'h00, 1'b1, 1'b1);
	endtask

	// zero length delimiter gives only the error mark
	task automatic test_bad_delimiter();
		wait_block_idle();
		cfg_write(dss_pkg::CFG_DELIM_LENGTH, 64'd0);
		send_text("qr", 1'b1);
		send_item(8'h00, 1'b0, 1'b1);
	endtask

	// limit of zero passes through, limit of two splits once
	task automatic test_split_limit();
		wait_block_idle();
		cfg_write(dss_pkg::CFG_DELIM_BYTES, text_to_delim(","));
		cfg_write(dss_pkg::CFG_DELIM_LENGTH, 64'd1);
		cfg_write(dss_pkg::CFG_SPLIT_LIMIT, 64'd0);
		send_text("a,b", 1'b1);
		wait_block_idle();
		cfg_write(dss_pkg::CFG_SPLIT_LIMIT, 64'd2);
		send_text("a,b,c", 1'b1);
	endtask

	// shorter delimiter while the window holds more bytes
	task automatic test_config_mid_string();
		wait_block_idle();
		cfg_write(dss_pkg::CFG_DELIM_BYTES, text_to_delim("wxyz"));
		cfg_write(dss_pkg::CFG_DELIM_LENGTH, 64'd4);
		cfg_write(dss_pkg::CFG_SPLIT_LIMIT, 64'(dss_pkg::RST_SPLIT_LIMIT));
		send_text("xyz", 1'b0);
		wait_block_idle();
		cfg_write(dss_pkg::CFG_DELIM_BYTES, text_to_delim("yz"));
		cfg_write(dss_pkg::CFG_DELIM_LENGTH, 64'd2);
		cfg_write(CFG_UNUSED, '1);
		send_text("yz", 1'b1);
	endtask

	// long receiver hold-off, then a sender pause until everything is out
	task automatic test_back_pressure();
		int k;
		wait_block_idle();
		tx_gaps_on = 1'b0;
		rx_gaps_on = 1'b0;
		cfg_write(dss_pkg::CFG_DELIM_BYTES, text_to_delim(","));
		cfg_write(dss_pkg::CFG_DELIM_LENGTH, 64'd1);
		cfg_write(dss_pkg::CFG_SPLIT_LIMIT, 64'd1);
		rx_hold_req = 250;
		for (k = 0; k < 40; k++)
			send_item(8'($urandom_range(0, 255)), 1'b1, k == 39);
		wait_block_idle();
		tx_gaps_on = 1'b1;
		rx_gaps_on = 1'b1;
		cfg_write(dss_pkg::CFG_SPLIT_LIMIT, 64'd3);
		for (k = 0; k < 16; k++)
			send_item((k % 3 == 0) ? 8'h2c : 8'($urandom_range(0, 255)), 1'b1, k == 15);
	endtask

	// random configurations and strings built from delimiter copies
	task automatic test_random_strings();
		int unsigned sent;
		int unsigned phase;
		int unsigned d;
		int unsigned span;
		int unsigned k;
		logic [63:0] data;
		logic [7:0] body [$];
		bit bare_end;
		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			wait_block_idle();
			tx_gaps_on = $urandom_range(0, 3) != 0;
			rx_gaps_on = $urandom_range(0, 3) != 0;
			// delimiter bytes: zeros first, sometimes all ones
			if (phase == 0)
				data = '0;
			else if ($urandom_range(0, 7) == 0)
				data = '1;
			else
				for (k = 0; k < 8; k++)
					data[8 * k +: 8] = alphabet_byte();
			cfg_write(dss_pkg::CFG_DELIM_BYTES, data);
			// delimiter length, junk in the upper data bits
			data = {$urandom, $urandom};
			case ($urandom_range(0, 9))
				0: data[3:0] = 4'd0;
				1: data[3:0] = 4'($urandom_range(9, 15));
				2: data[3:0] = 4'd8;
				default: data[3:0] = 4'($urandom_range(1, 4));
			endcase
			if (phase == 0)
				data[3:0] = 4'd2;
			cfg_write(dss_pkg::CFG_DELIM_LENGTH, data);
			// split limit
			data = {$urandom, $urandom};
			case ($urandom_range(0, 5))
				0: data[30:0] = 31'd0;
				1: data[30:0] = 31'd1;
				2: data[30:0] = 31'($urandom_range(2, 4));
				3: data[30:0] = 31'h7fff_ffff;
				4: data[30:0] = 31'($urandom);
				default: data[30:0] = 31'($urandom_range(5, 10));
			endcase
			cfg_write(dss_pkg::CFG_SPLIT_LIMIT, data);
			if ($urandom_range(0, 3) == 0)
				cfg_write(CFG_UNUSED, {$urandom, $urandom});
			d = (cfg_delim_len > dss_pkg::MAX_DELIM_BYTES) ?
				dss_pkg::MAX_DELIM_BYTES : cfg_delim_len;
			repeat ($urandom_range(3, 6)) begin
				body.delete();
				if ($urandom_range(0, 5) == 0) begin
					// noise string
					span = $urandom_range(1, 12);
					repeat (span) body = {body, 8'($urandom_range(0, 255))};
				end else if ($urandom_range(0, 11) != 0) begin
					repeat ($urandom_range(1, 4)) begin
						span = $urandom_range(0, 4);
						repeat (span) body = {body, pick_symbol()};
						// whole delimiter copy, or a cut-off one
						span = ($urandom_range(0, 3) != 0) ? d : $urandom_range(0, d);
						for (k = 0; k < span; k++)
							body = {body, cfg_delim_bytes[8 * k +: 8]};
					end
				end
				bare_end = (body.size() == 0) || ($urandom_range(0, 5) == 0);
				for (k = 0; k < body.size(); k++) begin
					if ($urandom_range(0, 14) == 0)
						send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
					send_item(body[k], 1'b1, !bare_end && (k + 1 == body.size()));
				end
				if (bare_end)
					send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
				sent += body.size() + bare_end;
			end
			// leave a string open across the next configuration change
			if ($urandom_range(0, 2) == 0) begin
				span = $urandom_range(1, 5);
				repeat (span) send_item(pick_symbol(), 1'b1, 1'b0);
				sent += span;
			end
			phase++;
		end
		send_item(8'h00, 1'b0, 1'b1);
	endtask

	// reset, tests in turn, final verdict
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = dss_pkg::CFG_DELIM_BYTES;
		cfg_data = '0;
		in_valid = 1'b0;
		in_item = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		test_basic_split();
		test_long_delimiter();
		test_bad_delimiter();
		test_split_limit();
		test_config_mid_string();
		test_back_pressure();
		test_random_strings();
		wait_block_idle();
		if (piece_stream.size() != 0)
			fail_count++;
		if (fail_count == 0)
			$display("delimiter_string_splitter_tb passed");
		else
			$display("delimiter_string_splitter_tb failed");
		$finish;
	end

endmodule

// File: files.f
rtl/core/dss_pkg.sv
rtl/core/dss_in_stage.sv
rtl/core/dss_engine.sv
rtl/core/dss_out_stage.sv
rtl/core/delimiter_string_splitter.sv
bench/delimiter_string_splitter_tb.sv
